FILE: hdl/blecw_pkg.sv
package blecw_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CRC_W  = 24;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned CHAN_W = 7;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned SLOTS  = 8;
    localparam int unsigned WIN_W  = 32;

    localparam logic [1:0] REG_ACCESS_ADDRESS = 2'd0;
    localparam logic [1:0] REG_CRC_SEED       = 2'd1;
    localparam logic [1:0] REG_CHANNEL_OFFSET = 2'd2;

    localparam logic [31:0]       ACCESS_ADDRESS_RST = 32'h8E89_BED6;
    localparam logic [CRC_W-1:0]  CRC_SEED_RST       = 24'hAA_AAAA;
    localparam logic [CHAN_W-1:0] CHANNEL_OFFSET_RST = 7'd24;

    localparam logic [CRC_W-1:0] CRC_POLY = 24'h5A_6000;
    localparam logic [CRC_W-1:0] CRC_TOP  = 24'h80_0000;

    localparam logic [POS_W:0] WSEQ_LEN = 8'd127;

    // Whitening sequence, entry 0 leftmost
    localparam logic [0:126] WSEQ = {
        22'b1111010101000010110111,
        22'b1001110010101100110000,
        22'b0110110101110100011001,
        22'b0001000000100100110100,
        22'b1111011100001111111000,
        17'b11101100010100101
    };

    localparam logic [0:39][POS_W-1:0] CHAN_START = {
        7'd70, 7'd62, 7'd120, 7'd111, 7'd77, 7'd46, 7'd15, 7'd101, 7'd66, 7'd39,
        7'd31, 7'd26, 7'd80, 7'd83, 7'd125, 7'd89, 7'd10, 7'd35, 7'd8, 7'd54,
        7'd122, 7'd17, 7'd33, 7'd0, 7'd58, 7'd115, 7'd6, 7'd94, 7'd86, 7'd49,
        7'd52, 7'd20, 7'd40, 7'd27, 7'd84, 7'd90, 7'd63, 7'd112, 7'd47, 7'd102
    };

    typedef struct packed {
        logic [31:0]       access_address;
        logic [CRC_W-1:0]  crc_seed;
        logic [CHAN_W-1:0] channel_offset;
    } cfg_t;

    // Results of one input item, slot 0 goes out first
    typedef struct packed {
        logic [SLOTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]      count;
        logic                  crc_tail;
    } bundle_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = b[k];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        logic             nb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            nb = c[0] ^ b[k];
            c  = c >> 1;
            if (nb) begin
                c = (c | CRC_TOP) ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [POS_W-1:0] chan_start_of(input logic [CHAN_W-1:0] off);
        logic [5:0] h;
        logic [5:0] idx;
        h = off[CHAN_W-1:1];
        if (h == 6'd0) begin
            idx = 6'd37;
        end else if (h < 6'd12) begin
            idx = h - 6'd1;
        end else if (h == 6'd12) begin
            idx = 6'd38;
        end else if (h < 6'd39) begin
            idx = h - 6'd2;
        end else begin
            idx = 6'd39;
        end
        return CHAN_START[idx];
    endfunction

    // Whitening bits for positions pos .. pos+31, wrapping at the sequence length
    function automatic logic [WIN_W-1:0] wseq_window(input logic [POS_W-1:0] pos);
        logic [WIN_W-1:0] w;
        logic [POS_W:0]   idx;
        for (int k = 0; k < WIN_W; k++) begin
            idx = {1'b0, pos} + (POS_W+1)'(k);
            if (idx >= WSEQ_LEN) begin
                idx = idx - WSEQ_LEN;
            end
            w[k] = WSEQ[idx[POS_W-1:0]];
        end
        return w;
    endfunction

endpackage

FILE: hdl/blecw_regs.sv
module blecw_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blecw_pkg::ADDR_W-1:0]  paddr,
    input  logic [blecw_pkg::DATA_W-1:0]  pwdata,
    output logic [blecw_pkg::DATA_W-1:0]  prdata,
    output blecw_pkg::cfg_t               cfg
);

    blecw_pkg::cfg_t cfg_reg;
    blecw_pkg::cfg_t cfg_next;
    logic [1:0]      reg_sel;
    logic            wr_en;

    assign reg_sel = paddr[blecw_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                blecw_pkg::REG_ACCESS_ADDRESS: cfg_next.access_address = pwdata;
                blecw_pkg::REG_CRC_SEED:
                    cfg_next.crc_seed = pwdata[blecw_pkg::CRC_W-1:0];
                blecw_pkg::REG_CHANNEL_OFFSET:
                    cfg_next.channel_offset = pwdata[blecw_pkg::CHAN_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.access_address <= blecw_pkg::ACCESS_ADDRESS_RST;
            cfg_reg.crc_seed       <= blecw_pkg::CRC_SEED_RST;
            cfg_reg.channel_offset <= blecw_pkg::CHANNEL_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            blecw_pkg::REG_ACCESS_ADDRESS: prdata = cfg_reg.access_address;
            blecw_pkg::REG_CRC_SEED:
                prdata = {{(blecw_pkg::DATA_W-blecw_pkg::CRC_W){1'b0}}, cfg_reg.crc_seed};
            blecw_pkg::REG_CHANNEL_OFFSET:
                prdata = {{(blecw_pkg::DATA_W-blecw_pkg::CHAN_W){1'b0}},
                          cfg_reg.channel_offset};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/blecw_frame.sv
module blecw_frame (
    input  logic              aclk,
    input  logic              aresetn,
    input  blecw_pkg::cfg_t   cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_pdu_byte,
    input  logic              s_first_byte,
    input  logic              s_last_byte,
    input  logic              bundle_free,
    output logic              bundle_load,
    output blecw_pkg::bundle_t bundle
);

    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    pdu_reg;
    logic                          first_reg;
    logic                          last_reg;
    logic [blecw_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [blecw_pkg::POS_W-1:0]   wpos_reg, wpos_next;

    logic                          accept;
    logic [blecw_pkg::CRC_W-1:0]   crc_start;
    logic [blecw_pkg::CRC_W-1:0]   crc_new;
    logic [blecw_pkg::POS_W-1:0]   pos0;
    logic [blecw_pkg::WIN_W-1:0]   win;
    logic [blecw_pkg::POS_W:0]     pos_sum;
    logic [blecw_pkg::SLOTS-1:0][7:0] slots;
    logic [7:0]                    aa_byte [4];
    logic [7:0]                    crc_out [3];
    logic [7:0]                    pdu_out;

    assign accept      = s_valid && s_ready;
    assign s_ready     = !in_valid_reg || bundle_free;
    assign bundle_load = in_valid_reg && bundle_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (bundle_load) begin
            in_valid_next = 1'b0;
        end
    end

    // Start state: a first byte restarts CRC and whitening
    assign crc_start = first_reg ? cfg.crc_seed : crc_reg;
    assign pos0      = first_reg ? blecw_pkg::chan_start_of(cfg.channel_offset) : wpos_reg;
    assign crc_new   = blecw_pkg::crc_byte(crc_start, pdu_reg);
    assign win       = blecw_pkg::wseq_window(pos0);
    assign pdu_out   = blecw_pkg::rev8(pdu_reg ^ win[7:0]);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            aa_byte[i] = blecw_pkg::rev8(cfg.access_address[8*i +: 8]);
        end
        for (int i = 0; i < 3; i++) begin
            crc_out[i] = blecw_pkg::rev8(crc_new[8*i +: 8] ^ win[8+8*i +: 8]);
        end
    end

    always_comb begin
        pos_sum = {1'b0, pos0} + (last_reg ? 8'd32 : 8'd8);
        if (pos_sum >= blecw_pkg::WSEQ_LEN) begin
            pos_sum = pos_sum - blecw_pkg::WSEQ_LEN;
        end
    end

    always_comb begin
        slots = {crc_out[2], crc_out[1], crc_out[0], pdu_out,
                 aa_byte[3], aa_byte[2], aa_byte[1], aa_byte[0]};
        // drop the address slots when the packet is already running
        bundle.bytes    = first_reg ? slots : (slots >> 32);
        bundle.count    = 4'd1 + (first_reg ? 4'd4 : 4'd0) + (last_reg ? 4'd3 : 4'd0);
        bundle.crc_tail = last_reg;
    end

    always_comb begin
        crc_next  = crc_reg;
        wpos_next = wpos_reg;
        if (bundle_load) begin
            crc_next  = crc_new;
            wpos_next = pos_sum[blecw_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            crc_reg      <= '0;
            wpos_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            crc_reg      <= crc_next;
            wpos_reg     <= wpos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pdu_reg   <= s_pdu_byte;
            first_reg <= s_first_byte;
            last_reg  <= s_last_byte;
        end
    end

endmodule

FILE: hdl/blecw_serial.sv
module blecw_serial (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               bundle_load,
    input  blecw_pkg::bundle_t bundle,
    output logic               bundle_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_out
);

    logic [blecw_pkg::SLOTS-1:0][7:0] bytes_reg, bytes_next;
    logic [blecw_pkg::CNT_W-1:0]      remaining_reg, remaining_next;
    logic                             crc_tail_reg, crc_tail_next;
    logic                             take;

    assign m_valid     = remaining_reg != '0;
    assign take        = m_valid && m_ready;
    assign bundle_free = (remaining_reg == '0)
                      || (remaining_reg == blecw_pkg::CNT_W'(1) && m_ready);
    assign m_out_byte  = bytes_reg[0];
    assign m_last_out  = crc_tail_reg && (remaining_reg == blecw_pkg::CNT_W'(1));

    always_comb begin
        bytes_next     = bytes_reg;
        remaining_next = remaining_reg;
        crc_tail_next  = crc_tail_reg;
        if (bundle_load) begin
            bytes_next     = bundle.bytes;
            remaining_next = bundle.count;
            crc_tail_next  = bundle.crc_tail;
        end else if (take) begin
            // advance to the next byte of the transaction group
            bytes_next     = bytes_reg >> 8;
            remaining_next = remaining_reg - blecw_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
        end else begin
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg    <= bytes_next;
        crc_tail_reg <= crc_tail_next;
    end

endmodule

FILE: hdl/ble_packet_crc_and_whitening.sv
// BLE transmit framing: access address, CRC-24 and data whitening.
// Input channel (s_valid/s_ready): one PDU byte per transaction, with
// s_first_byte marking the start of a packet and s_last_byte its end.
// Output channel (m_valid/m_ready): one wire byte per transaction, MSB first.
// An item yields 1 byte, plus 4 access-address bytes when first, plus 3
// whitened CRC bytes when last; m_last_out flags the final CRC byte.
// The first result byte of an item is offered once the item has passed
// the input register, which takes it at acceptance, and then the result
// register, which loads it as soon as the output side is free.
// Throughput: while m_ready is high the output port sets the pace at one
// byte per cycle, so an item with k result bytes (1 to 8) occupies it for k
// transfers; single-byte items flow back to back at one per cycle while it stays high.
// A new item is accepted while the last byte of the previous one is taken.
// When m_ready is low, results hold in the result register and one further
// item waits in the input register before s_ready drops.
// Configuration (APB, addresses 0x0, 0x4, 0x8) must be written while idle; the block itself does not enforce it.
// Reset: registers return to their defaults, CRC state and whitening
// position clear to zero, and both channels empty.
module ble_packet_crc_and_whitening (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [blecw_pkg::ADDR_W-1:0] paddr,
    input  logic [blecw_pkg::DATA_W-1:0] pwdata,
    output logic [blecw_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_pdu_byte,
    input  logic                         s_first_byte,
    input  logic                         s_last_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_out_byte,
    output logic                         m_last_out
);

    blecw_pkg::cfg_t    cfg;
    blecw_pkg::bundle_t bundle;
    logic               bundle_free;
    logic               bundle_load;

    assign pready = 1'b1;

    blecw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    blecw_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pdu_byte   (s_pdu_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .bundle_free  (bundle_free),
        .bundle_load  (bundle_load),
        .bundle       (bundle)
    );

    blecw_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bundle_load (bundle_load),
        .bundle      (bundle),
        .bundle_free (bundle_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_out  (m_last_out)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    class frame_scoreboard;
        logic [31:0]                 access_address;
        logic [blecw_pkg::CRC_W-1:0] crc_seed;
        logic [6:0]                  chan_offset;
        logic [blecw_pkg::CRC_W-1:0] crc_state;
        logic [6:0]                  wpos;
        wire_byte_t                  wire_bytes_due[$];
        int                          mismatches;

        function new();
            access_address = blecw_pkg::ACCESS_ADDRESS_RST;
            crc_seed       = blecw_pkg::CRC_SEED_RST;
            chan_offset    = blecw_pkg::CHANNEL_OFFSET_RST;
            crc_state      = '0;
            wpos           = '0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                blecw_pkg::REG_ACCESS_ADDRESS: begin
                    access_address = value;
                end
                blecw_pkg::REG_CRC_SEED: begin
                    crc_seed = value[blecw_pkg::CRC_W-1:0];
                end
                blecw_pkg::REG_CHANNEL_OFFSET: begin
                    chan_offset = value[6:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [7:0] mirror8(logic [7:0] b);
            logic [7:0] r;
            for (int k = 0; k < 8; k++) begin
                r[7-k] = b[k];
            end
            return r;
        endfunction

        // whiten LSB first, hand back in wire order
        function logic [7:0] whiten(logic [7:0] b);
            logic [7:0] w;
            for (int k = 0; k < 8; k++) begin
                w[k] = b[k] ^ blecw_pkg::WSEQ[wpos];
                wpos = (wpos == 7'd126) ? 7'd0 : wpos + 7'd1;
            end
            return mirror8(w);
        endfunction

        function void push_byte(logic [7:0] data, logic last);
            wire_byte_t item;
            item.data = data;
            item.last = last;
            wire_bytes_due.push_back(item);
        endfunction

        function void note_pdu(logic [7:0] b, logic first, logic last);
            logic [5:0]                  half;
            int                          idx;
            logic                        fb;
            logic [blecw_pkg::CRC_W-1:0] crc_snap;
            if (first) begin
                crc_state = crc_seed;
                half = chan_offset[6:1];
                if (half == 6'd0) begin
                    idx = 37;
                end else if (half < 6'd12) begin
                    idx = half - 1;
                end else if (half == 6'd12) begin
                    idx = 38;
                end else if (half < 6'd39) begin
                    idx = half - 2;
                end else begin
                    idx = 39;
                end
                wpos = blecw_pkg::CHAN_START[idx];
                for (int i = 0; i < 4; i++) begin
                    push_byte(mirror8(access_address[8*i +: 8]), 1'b0);
                end
            end
            for (int k = 0; k < 8; k++) begin
                fb = crc_state[0] ^ b[k];
                crc_state = crc_state >> 1;
                if (fb) begin
                    crc_state = (crc_state | blecw_pkg::CRC_TOP) ^ blecw_pkg::CRC_POLY;
                end
            end
            push_byte(whiten(b), 1'b0);
            if (last) begin
                crc_snap = crc_state;
                for (int i = 0; i < 3; i++) begin
                    push_byte(whiten(crc_snap[8*i +: 8]), i == 2);
                end
            end
        endfunction

        function void check_wire_byte(logic [7:0] data, logic last);
            wire_byte_t due;
            if (wire_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected wire byte %02h last %0b at %0t", data, last, $realtime);
                end
                return;
            end
            due = wire_bytes_due.pop_front();
            if (due.data !== data || due.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("wire byte mismatch at %0t: expected %02h last %0b, got %02h last %0b",
                             $realtime, due.data, due.last, data, last);
                end
            end
        endfunction

        function int pending();
            return wire_bytes_due.size();
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [blecw_pkg::ADDR_W-1:0] paddr = '0;
    logic [blecw_pkg::DATA_W-1:0] pwdata = '0;
    logic [blecw_pkg::DATA_W-1:0] prdata;
    logic                         pready;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_pdu_byte = '0;
    logic                         s_first_byte = 1'b0;
    logic                         s_last_byte = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [7:0]                   m_out_byte;
    logic                         m_last_out;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic rx_hold_req = 1'b0;

    frame_scoreboard frames = new();

    ble_packet_crc_and_whitening dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pdu_byte   (s_pdu_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last_out   (m_last_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off on request
    always begin
        @(posedge aclk);
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            m_ready <= 1'b0;
            repeat (300) @(posedge aclk);
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // sample mid-cycle: inputs only move at the rising edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames.check_wire_byte(m_out_byte, m_last_out);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= blecw_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.write_reg(idx, value);
        // leave the bus idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic send_pdu(input logic [7:0] b, input logic first, input logic last);
        logic taken;
        s_valid      <= 1'b1;
        s_pdu_byte   <= b;
        s_first_byte <= first;
        s_last_byte  <= last;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        frames.note_pdu(b, first, last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // drop valid and let every expected byte drain before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (frames.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_random_config();
        reg_write(blecw_pkg::REG_ACCESS_ADDRESS, $urandom);
        reg_write(blecw_pkg::REG_CRC_SEED, $urandom_range(32'h00FF_FFFF));
        if ($urandom_range(3) == 0) begin
            reg_write(blecw_pkg::REG_CHANNEL_OFFSET, $urandom_range(127));
        end else begin
            reg_write(blecw_pkg::REG_CHANNEL_OFFSET, $urandom_range(78));
        end
    endtask

    // mostly well-formed packets, some stray bytes with random markers
    task automatic send_stream(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                send_pdu(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                for (int i = 0; i < len; i++) begin
                    send_pdu(8'($urandom_range(255)), i == 0, i == len - 1);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no packet started yet: CRC and whitening run from cleared state
        send_pdu(8'h00, 1'b0, 1'b0);
        send_pdu(8'hFF, 1'b0, 1'b1);
        send_pdu(8'h5A, 1'b1, 1'b1);
        send_pdu(8'h01, 1'b1, 1'b0);
        send_pdu(8'h80, 1'b0, 1'b0);
        send_pdu(8'hFF, 1'b0, 1'b1);
        // carry on after last without a new first
        send_pdu(8'h3C, 1'b0, 1'b0);
        send_pdu(8'hC3, 1'b0, 1'b1);

        settle();
        reg_write(blecw_pkg::REG_ACCESS_ADDRESS, 32'hFFFF_FFFF);
        reg_write(blecw_pkg::REG_CRC_SEED, 32'h00FF_FFFF);
        reg_write(blecw_pkg::REG_CHANNEL_OFFSET, 32'd127);
        send_pdu(8'h00, 1'b1, 1'b0);
        send_pdu(8'hFF, 1'b0, 1'b0);
        send_pdu(8'hAA, 1'b0, 1'b1);

        settle();
        reg_write(blecw_pkg::REG_ACCESS_ADDRESS, 32'h0);
        reg_write(blecw_pkg::REG_CRC_SEED, 32'h0);
        reg_write(blecw_pkg::REG_CHANNEL_OFFSET, 32'h0);
        send_pdu(8'hFF, 1'b1, 1'b1);
        send_pdu(8'h00, 1'b1, 1'b1);

        // channel map corners: advertising channel 38, odd offset, first data, top
        settle();
        reg_write(blecw_pkg::REG_CHANNEL_OFFSET, 32'd24);
        send_pdu(8'hA5, 1'b1, 1'b1);
        settle();
        reg_write(blecw_pkg::REG_CHANNEL_OFFSET, 32'd25);
        send_pdu(8'hA5, 1'b1, 1'b1);
        settle();
        reg_write(blecw_pkg::REG_CHANNEL_OFFSET, 32'd2);
        send_pdu(8'hA5, 1'b1, 1'b1);
        settle();
        reg_write(blecw_pkg::REG_CHANNEL_OFFSET, 32'd78);
        send_pdu(8'hA5, 1'b1, 1'b1);

        for (int ph = 0; ph < 5; ph++) begin
            for (int blk = 0; blk < 4; blk++) begin
                settle();
                case (ph)
                    1: begin
                        tx_idle_pct = 67;
                        rx_stall_pct = 0;
                    end
                    2: begin
                        tx_idle_pct = 0;
                        rx_stall_pct = 67;
                    end
                    3: begin
                        tx_idle_pct = 15;
                        rx_stall_pct = 15;
                    end
                    default: begin
                        tx_idle_pct = 0;
                        rx_stall_pct = 0;
                    end
                endcase
                write_random_config();
                if (ph == 0 && blk == 0) begin
                    rx_hold_req = 1'b1;
                end
                send_stream(25);
            end
        end

        s_valid <= 1'b0;
        while (frames.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (frames.mismatches == 0 && frames.pending() == 0) begin
            $display("ble_packet_crc_and_whitening verification clean");
        end else begin
            $display("ble_packet_crc_and_whitening verification failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("ble_packet_crc_and_whitening verification failed");
        $finish;
    end

endmodule
